[rtl/msp_rx_pkg.sv]
// Shared types and constants for the MSP v1 frame receiver.
package msp_rx_pkg;

	localparam logic [7:0] MARK_BYTE = 8'h4D;

	localparam logic [7:0] PREAMBLE_RST = 8'd36;
	localparam logic [7:0] DIR_TO_RST   = 8'd60;
	localparam logic [7:0] DIR_FROM_RST = 8'd62;
	localparam logic [7:0] SIZE_LIM_RST = 8'd64;

	localparam logic [1:0] REG_PREAMBLE = 2'd0;
	localparam logic [1:0] REG_DIR_TO   = 2'd1;
	localparam logic [1:0] REG_DIR_FROM = 2'd2;
	localparam logic [1:0] REG_SIZE_LIM = 2'd3;

	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HEADER  = 3'd1;
	localparam logic [2:0] ST_DIR     = 3'd2;
	localparam logic [2:0] ST_LONG    = 3'd3;
	localparam logic [2:0] ST_SUM     = 3'd4;
	localparam logic [2:0] ST_TIMEOUT = 3'd5;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_MARK,
		PH_DIR,
		PH_SIZE,
		PH_CMD,
		PH_BODY,
		PH_SUM
	} phase_t;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [7:0] command;
		logic       from_controller;
		logic [7:0] frame_size;
		logic [2:0] status;
	} out_t;

endpackage

[rtl/msp_rx_parser.sv]
// Header/payload/checksum state machine with its configuration registers.
module msp_rx_parser import msp_rx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       take,
	input  in_t        item,
	output logic       res_valid,
	output out_t       res_item
);

	logic [7:0] preamble_q, dir_to_q, dir_from_q, size_lim_q;

	phase_t     phase_q, phase_d;
	logic       dir_q, dir_d;
	logic [7:0] len_q, len_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] cnt_q, cnt_d;
	logic [7:0] xor_q, xor_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= PREAMBLE_RST;
			dir_to_q   <= DIR_TO_RST;
			dir_from_q <= DIR_FROM_RST;
			size_lim_q <= SIZE_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PREAMBLE: preamble_q <= cfg_data;
				REG_DIR_TO:   dir_to_q   <= cfg_data;
				REG_DIR_FROM: dir_from_q <= cfg_data;
				REG_SIZE_LIM: size_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			dir_q   <= 1'b0;
			len_q   <= '0;
			cmd_q   <= '0;
			cnt_q   <= '0;
			xor_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			dir_q   <= dir_d;
			len_q   <= len_d;
			cmd_q   <= cmd_d;
			cnt_q   <= cnt_d;
			xor_q   <= xor_d;
		end
	end

	logic       hit;
	logic       kind;
	logic [7:0] data;
	logic [2:0] status;
	logic [7:0] b;
	logic [7:0] cnt_inc;

	assign b       = item.rx_byte;
	assign cnt_inc = cnt_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		dir_d   = dir_q;
		len_d   = len_q;
		cmd_d   = cmd_q;
		cnt_d   = cnt_q;
		xor_d   = xor_q;
		hit     = 1'b0;
		kind    = KIND_END;
		data    = '0;
		status  = ST_OK;
		if (item.op == OP_TIMEOUT) begin
			if (phase_q != PH_HUNT) begin
				hit     = 1'b1;
				status  = ST_TIMEOUT;
				phase_d = PH_HUNT;
			end
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (b == preamble_q) begin
						dir_d   = 1'b0;
						len_d   = '0;
						cmd_d   = '0;
						cnt_d   = '0;
						xor_d   = '0;
						phase_d = PH_MARK;
					end
				end
				PH_MARK: begin
					if (b != MARK_BYTE) begin
						hit     = 1'b1;
						status  = ST_HEADER;
						phase_d = PH_HUNT;
					end else begin
						phase_d = PH_DIR;
					end
				end
				PH_DIR: begin
					if (b == dir_from_q) begin
						dir_d   = 1'b1;
						phase_d = PH_SIZE;
					end else if (b == dir_to_q) begin
						dir_d   = 1'b0;
						phase_d = PH_SIZE;
					end else begin
						hit     = 1'b1;
						status  = ST_DIR;
						phase_d = PH_HUNT;
					end
				end
				PH_SIZE: begin
					len_d = b;
					if (b > size_lim_q) begin
						hit     = 1'b1;
						status  = ST_LONG;
						phase_d = PH_HUNT;
					end else begin
						xor_d   = b;
						phase_d = PH_CMD;
					end
				end
				PH_CMD: begin
					cmd_d   = b;
					xor_d   = xor_q ^ b;
					cnt_d   = '0;
					phase_d = (len_q == 8'd0) ? PH_SUM : PH_BODY;
				end
				PH_BODY: begin
					xor_d = xor_q ^ b;
					cnt_d = cnt_inc;
					if (cnt_inc >= len_q)
						phase_d = PH_SUM;
					hit  = 1'b1;
					kind = KIND_PAYLOAD;
					data = b;
				end
				PH_SUM: begin
					hit     = 1'b1;
					data    = b;
					status  = (b == xor_q) ? ST_OK : ST_SUM;
					phase_d = PH_HUNT;
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// fields reflect the frame state as updated by this beat
	assign res_valid                = take & hit;
	assign res_item.kind            = kind;
	assign res_item.data            = data;
	assign res_item.command         = cmd_d;
	assign res_item.from_controller = dir_d;
	assign res_item.frame_size      = len_d;
	assign res_item.status          = status;

endmodule

[rtl/msp_v1_frame_receiver.sv]
// A result appears on the output register in the cycle after its input beat.
// Throughput: one beat per cycle; in_stall rises only while the output register
// holds a result that out_stall keeps from leaving.
// Reset (arst_n low): configuration to its defaults, parser to preamble hunt,
// output register empty.
// Top level of the MSP v1 frame receiver.
module msp_v1_frame_receiver import msp_rx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_t        in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_item
);

	logic out_valid_q;
	out_t out_item_q;
	logic take;
	logic load;
	logic res_valid;
	out_t res_item;

	assign load     = !out_valid_q || !out_stall;
	assign in_stall = !load;
	assign take     = in_valid && load;

	msp_rx_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.item      (in_item),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (load && res_valid)
			out_item_q <= res_item;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

[rtl/msp_rx_checker.sv]
// Port-level checks for the MSP v1 frame receiver, bound to the top level.
module msp_rx_assert import msp_rx_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input out_t       out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output beat changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked output");

	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == KIND_PAYLOAD |-> out_item.status == ST_OK)
		else $error("payload beat with nonzero status");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status <= ST_TIMEOUT)
		else $error("status out of range");

	a_err_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == KIND_END &&
		(out_item.status == ST_HEADER || out_item.status == ST_DIR ||
		 out_item.status == ST_LONG || out_item.status == ST_TIMEOUT)
		|-> out_item.data == 8'd0)
		else $error("error frame end carries checksum data");

endmodule

bind msp_v1_frame_receiver msp_rx_assert u_msp_rx_assert (.*);
